/* src/wma_pkg.sv */
// ----------------------------------------------------------------------------
// wma_pkg: shared types and constants for the windowed moving average
// Holds the sample width, the default window depth and the command struct
// that the controller sends to the datapath.
// ----------------------------------------------------------------------------
package wma_pkg;

   localparam int SAMPLE_W       = 32;
   localparam int DEFAULT_WINDOW = 16;

   typedef struct packed {
      logic accept;     // item transfer on the request channel
      logic clear_item; // accepted item is a clear
      logic update;     // write store, update sum, count and position
      logic div_load;   // load divider from running sum
      logic div_step;   // one restoring division step
      logic out_load;   // load result register
   } dp_cmd_type;

endpackage

/* src/windowed_moving_average.sv */
// ----------------------------------------------------------------------------
// windowed_moving_average: moving average over the last WINDOW samples
// Top level: joins the sequencer and the datapath and checks key properties.
// ----------------------------------------------------------------------------
// Each request transfer either clears the window (clear = 1, sample ignored)
// or pushes one signed 32-bit sample into a ring of WINDOW entries. Exactly
// one response follows per request: the mean of the held samples truncated
// toward zero, and the number of samples held. A sample request passes
// through store update, divider load and the bit-serial divider, which makes
// one quotient bit per cycle over the SUM_W-bit running sum, to the result
// hand-off; a clear goes straight to hand-off. One request is in work at a
// time; a new one is taken as soon as the previous result sits in the
// response register, even if that result has not yet been taken.
// The sample store is not cleared at reset; an entry read back is only used
// once the ring is full, so every used read hits a written entry.
module windowed_moving_average import wma_pkg::*; #(
   parameter int WINDOW = DEFAULT_WINDOW,
   // derived; leave at default
   parameter int CNT_W  = $clog2(WINDOW + 1),
   parameter int SUM_W  = SAMPLE_W + CNT_W
) (
   input  logic                       clock,
   input  logic                       reset,
   // request channel
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_clear,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   // response channel
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [SAMPLE_W-1:0] rsp_average,
   output logic        [CNT_W-1:0]    rsp_filled_count
);

   dp_cmd_type cmd;

   // sequencer: ready, response valid and datapath commands
   wma_ctrl #(
      .SUM_W (SUM_W)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_clear (req_clear),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   // ring, running sum, divider and response register
   wma_dp #(
      .WINDOW (WINDOW),
      .CNT_W  (CNT_W),
      .SUM_W  (SUM_W)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_sample       (req_sample),
      .rsp_average      (rsp_average),
      .rsp_filled_count (rsp_filled_count)
   );

   // one item in work: no transfer right after a transfer
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while an item is in work");

   // fill count never passes the window depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_filled_count <= CNT_W'(WINDOW)))
      else $error("filled count above window depth");

   // an empty window reports a zero mean
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_filled_count == '0) |-> (rsp_average == '0))
      else $error("nonzero average for empty window");

endmodule

/* src/wma_ctrl.sv */
// ----------------------------------------------------------------------------
// wma_ctrl: sequencer for the windowed moving average
// Steps one item through store update, divider load, division and result
// hand-off (a clear skips to hand-off); owns request ready and result valid.
// ----------------------------------------------------------------------------
module wma_ctrl import wma_pkg::*; #(
   parameter int SUM_W = SAMPLE_W + 5
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_clear,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output dp_cmd_type cmd
);

   localparam int STEP_W = (SUM_W > 1) ? $clog2(SUM_W) : 1;

   typedef enum logic [2:0] {
      IDLE,
      UPDATE,
      LOAD,
      DIVIDE,
      FINISH
   } state_type;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              out_free;

   assign req_ready = (state_ff == IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cmd            = '0;
      cmd.accept     = req_valid && req_ready;
      cmd.clear_item = cmd.accept && req_clear;
      cmd.update     = (state_ff == UPDATE);
      cmd.div_load   = (state_ff == LOAD);
      cmd.div_step   = (state_ff == DIVIDE);
      cmd.out_load   = (state_ff == FINISH) && out_free;
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         IDLE: begin
            if (cmd.accept) begin
               state_in = req_clear ? FINISH : UPDATE;
            end
         end
         UPDATE: begin
            state_in = LOAD;
         end
         LOAD: begin
            step_in  = STEP_W'(SUM_W - 1);
            state_in = DIVIDE;
         end
         DIVIDE: begin
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               state_in = FINISH;
            end
         end
         FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* src/wma_dp.sv */
// ----------------------------------------------------------------------------
// wma_dp: datapath for the windowed moving average
// Sample ring, running sum, fill count, bit-serial divider and result
// register.
// ----------------------------------------------------------------------------
module wma_dp import wma_pkg::*; #(
   parameter int WINDOW = DEFAULT_WINDOW,
   parameter int CNT_W  = 5,
   parameter int SUM_W  = SAMPLE_W + 5
) (
   input  logic                       clock,
   input  logic                       reset,
   input  dp_cmd_type                 cmd,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   output logic signed [SAMPLE_W-1:0] rsp_average,
   output logic        [CNT_W-1:0]    rsp_filled_count
);

   localparam int POS_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

   logic signed [SAMPLE_W-1:0] store_mem [WINDOW];
   logic signed [SAMPLE_W-1:0] old_ff;
   logic signed [SAMPLE_W-1:0] sample_ff;

   logic [POS_W-1:0]        pos_ff, pos_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic                    full;

   logic [SUM_W-1:0]   quo_ff, quo_in;
   logic [CNT_W-1:0]   rem_ff, rem_in;
   logic               neg_ff, neg_in;
   logic [CNT_W:0]     rem_shift;
   logic [CNT_W:0]     rem_diff;
   logic [SUM_W-1:0]   quo_signed;

   logic signed [SAMPLE_W-1:0] avg_ff;
   logic        [CNT_W-1:0]    cnt_out_ff;

   assign full = (count_ff == CNT_W'(WINDOW));

   // ring position, fill count and running sum
   always_comb begin
      pos_in   = pos_ff;
      count_in = count_ff;
      sum_in   = sum_ff;
      if (cmd.clear_item) begin
         pos_in   = '0;
         count_in = '0;
         sum_in   = '0;
      end else if (cmd.update) begin
         sum_in = sum_ff + SUM_W'(sample_ff);
         if (full) begin
            sum_in = sum_ff + SUM_W'(sample_ff) - SUM_W'(old_ff);
         end else begin
            count_in = count_ff + 1'b1;
         end
         pos_in = (pos_ff == POS_W'(WINDOW - 1)) ? '0 : pos_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         count_ff <= '0;
         sum_ff   <= '0;
      end else begin
         pos_ff   <= pos_in;
         count_ff <= count_in;
         sum_ff   <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         sample_ff <= req_sample;
         old_ff    <= store_mem[pos_ff];
      end
      if (cmd.update) begin
         store_mem[pos_ff] <= sample_ff;
      end
   end

   // restoring divider on the sum magnitude, one quotient bit per step
   assign rem_shift = {rem_ff, quo_ff[SUM_W-1]};
   assign rem_diff  = rem_shift - {1'b0, count_ff};

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      neg_in = neg_ff;
      if (cmd.clear_item) begin
         quo_in = '0;
         rem_in = '0;
         neg_in = 1'b0;
      end else if (cmd.div_load) begin
         quo_in = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
         rem_in = '0;
         neg_in = sum_ff[SUM_W-1];
      end else if (cmd.div_step) begin
         if (!rem_diff[CNT_W]) begin
            rem_in = rem_diff[CNT_W-1:0];
            quo_in = {quo_ff[SUM_W-2:0], 1'b1};
         end else begin
            rem_in = rem_shift[CNT_W-1:0];
            quo_in = {quo_ff[SUM_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      neg_ff <= neg_in;
   end

   assign quo_signed = neg_ff ? -quo_ff : quo_ff;

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         avg_ff     <= quo_signed[SAMPLE_W-1:0];
         cnt_out_ff <= count_ff;
      end
   end

   assign rsp_average      = avg_ff;
   assign rsp_filled_count = cnt_out_ff;

endmodule
